// File: rtl/core/plb_pkg.sv
// Package for the paint layer pixel blend: pipeline stage types and
// constant-divisor helpers (divide by 255 and by 255*255).
// No dependencies.
package plb_pkg;

    // full scale of an 8-bit channel and of the product of two
    localparam logic [7:0]  FULL8  = 8'd255;
    localparam logic [15:0] FULL16 = 16'd65025;

    // reciprocal constants: ceil(2^33/255) and ceil(2^40/65025)
    localparam logic [25:0] DIV255_MUL   = 26'd33686019;
    localparam logic [24:0] DIV65025_MUL = 25'd16909061;

    localparam logic [31:0] THICK_MAX = 32'hFFFF_FFFF;

    // floor(x/255), exact for any 25-bit x
    function automatic logic [17:0] div255(input logic [24:0] x);
        logic [50:0] p;
        p = 51'(x) * 51'(DIV255_MUL);
        return p[50:33];
    endfunction

    // floor(x/65025), exact for any 24-bit x
    function automatic logic [8:0] div65025(input logic [23:0] x);
        logic [48:0] p;
        p = 49'(x) * 49'(DIV65025_MUL);
        return p[48:40];
    endfunction

    // stage 1: blend factors and the narrow products
    typedef struct packed {
        logic             vis;
        logic [31:0]      dst_color;
        logic [31:0]      dst_surface;
        logic [31:0]      dst_thickness;
        logic [23:0]      lay_rgb;
        logic [15:0]      col_fac;
        logic [3:0][15:0] surf_num;
        logic [15:0]      alpha_num;
        logic [24:0]      thick_num;
    } s1_t;

    // stage 2: color sums and the divided surface, alpha and thickness
    typedef struct packed {
        logic             vis;
        logic [31:0]      dst_color;
        logic [31:0]      dst_surface;
        logic [31:0]      dst_thickness;
        logic [2:0][23:0] col_num;
        logic [3:0][7:0]  surf_q;
        logic [7:0]       alpha_q;
        logic [16:0]      thick_q;
    } s2_t;

endpackage

// File: rtl/core/paint_layer_pixel_blend.sv
// Paint layer pixel blend, top level: three-stage pipeline that blends one
// layer pixel over one composite pixel per item. Depends on plb_pkg.
//
//  channel | signals                               | direction | handshake
//  --------+---------------------------------------+-----------+-----------
//  input   | in_valid, in_stall, dst_*, layer_*    | in        | valid/stall
//  output  | out_valid, out_stall, out_*           | out       | valid/stall
//  config  | cfg_valid, cfg_ready, cfg_data        | in        | valid/ready
//
// One item enters per cycle unless in_stall is high. Each item passes the three
// register stages in order: products, divide by 255, divide by 65025 and
// thickness add. Stalls back up stage by stage, so a bubble in the pipe is
// filled while the output waits. Reset empties the pipe and sets the layer
// visibility register to 1. Config writes are taken every cycle.
module paint_layer_pixel_blend (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] dst_color,
    input  logic [31:0] dst_surface,
    input  logic [31:0] dst_thickness,
    input  logic [31:0] layer_color,
    input  logic [31:0] layer_surface,
    input  logic [16:0] layer_thickness,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_color,
    output logic [31:0] out_surface,
    output logic [31:0] out_thickness,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import plb_pkg::*;

    logic        vis_reg;
    logic        v1_reg, v2_reg, v3_reg;
    s1_t         s1_reg, s1_next;
    s2_t         s2_reg, s2_next;
    logic [31:0] col_reg, col_next;
    logic [31:0] surf_reg, surf_next;
    logic [31:0] thick_reg, thick_next;
    logic        adv1, adv2, adv3;

    // stage advance: a stage moves when empty or when the next one moves
    assign adv3     = !v3_reg || !out_stall;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_stall = !adv1;

    assign cfg_ready = 1'b1;

    // layer visibility register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vis_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            vis_reg <= cfg_data;
    end

    // stage 1: factor a*s, surface and alpha numerators, thickness product
    always_comb
    begin
        logic [7:0] a;
        logic [7:0] inv_a;
        logic [7:0] inv_da;
        a      = layer_color[31:24];
        inv_a  = FULL8 - a;
        inv_da = FULL8 - dst_color[31:24];
        s1_next.vis           = vis_reg;
        s1_next.dst_color     = dst_color;
        s1_next.dst_surface   = dst_surface;
        s1_next.dst_thickness = dst_thickness;
        s1_next.lay_rgb       = layer_color[23:0];
        s1_next.col_fac       = 16'(a) * 16'(layer_surface[23:16]);
        for (int k = 0; k < 4; k++)
        begin
            s1_next.surf_num[k] = 16'(dst_surface[8*k +: 8]) * 16'(inv_a)
                                + 16'(layer_surface[8*k +: 8]) * 16'(a);
        end
        s1_next.alpha_num = FULL16 - 16'(inv_da) * 16'(inv_a);
        s1_next.thick_num = 25'(layer_thickness) * 25'(a);
    end

    // stage 2: color sums, divide surface, alpha and thickness by 255
    always_comb
    begin
        logic [15:0] inv_fac;
        logic [17:0] q;
        inv_fac = FULL16 - s1_reg.col_fac;
        s2_next.vis           = s1_reg.vis;
        s2_next.dst_color     = s1_reg.dst_color;
        s2_next.dst_surface   = s1_reg.dst_surface;
        s2_next.dst_thickness = s1_reg.dst_thickness;
        for (int k = 0; k < 3; k++)
        begin
            s2_next.col_num[k] = 24'(s1_reg.dst_color[8*k +: 8]) * 24'(inv_fac)
                               + 24'(s1_reg.lay_rgb[8*k +: 8]) * 24'(s1_reg.col_fac);
        end
        for (int k = 0; k < 4; k++)
        begin
            q = div255(25'(s1_reg.surf_num[k]));
            s2_next.surf_q[k] = q[7:0];
        end
        q = div255(25'(s1_reg.alpha_num));
        s2_next.alpha_q = q[7:0];
        q = div255(s1_reg.thick_num);
        s2_next.thick_q = q[16:0];
    end

    // stage 3: divide color by 65025, saturating thickness add, bypass mux
    always_comb
    begin
        logic [8:0]  cq;
        logic [32:0] tsum;
        col_next[31:24] = s2_reg.alpha_q;
        for (int k = 0; k < 3; k++)
        begin
            cq = div65025(s2_reg.col_num[k]);
            col_next[8*k +: 8] = cq[7:0];
        end
        surf_next  = s2_reg.surf_q;
        tsum       = 33'(s2_reg.dst_thickness) + 33'(s2_reg.thick_q);
        thick_next = tsum[32] ? THICK_MAX : tsum[31:0];
        if (!s2_reg.vis)
        begin
            col_next   = s2_reg.dst_color;
            surf_next  = s2_reg.dst_surface;
            thick_next = s2_reg.dst_thickness;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    // payload registers, loaded only with a valid item
    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
            s1_reg <= s1_next;
        if (adv2 && v1_reg)
            s2_reg <= s2_next;
        if (adv3 && v2_reg)
        begin
            col_reg   <= col_next;
            surf_reg  <= surf_next;
            thick_reg <= thick_next;
        end
    end

    assign out_valid     = v3_reg;
    assign out_color     = col_reg;
    assign out_surface   = surf_reg;
    assign out_thickness = thick_reg;

endmodule

// File: rtl/core/plb_checker.sv
// Port-level checker for the paint layer pixel blend, with its bind.
// Depends on paint_layer_pixel_blend's port list only.
module plb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] out_color,
    input logic [31:0] out_surface,
    input logic [31:0] out_thickness,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_color) && $stable(out_surface)
                                   && $stable(out_thickness))
        else $error("result payload changed while stalled");

    // the input only stalls when a result waits at a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with room in the pipe");

    // config writes are never held off
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write held off");

endmodule

bind paint_layer_pixel_blend plb_checker u_plb_checker (.*);

// File: test/tb_paint_layer_pixel_blend.sv
// Testbench for paint_layer_pixel_blend: drives composite and layer pixels,
// predicts each blended pixel in its own function and checks results in order.
// Depends on the block under test only.
module tb_paint_layer_pixel_blend;

    localparam int unsigned CH_FULL    = 255;
    localparam int unsigned FAC_FULL   = 65025;
    localparam logic [31:0] THICK_TOP  = 32'hFFFF_FFFF;
    localparam int          IDLE_LIMIT = 5000;
    localparam int          PIPE_DEPTH = 3;
    localparam int          HOLD_LEN   = 60;

    typedef struct packed {
        logic [31:0] color;
        logic [31:0] surface;
        logic [31:0] thickness;
    } blend_px_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] dst_color;
    logic [31:0] dst_surface;
    logic [31:0] dst_thickness;
    logic [31:0] layer_color;
    logic [31:0] layer_surface;
    logic [16:0] layer_thickness;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] out_color;
    logic [31:0] out_surface;
    logic [31:0] out_thickness;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    // expected blended pixels, oldest first
    blend_px_t   blend_q[$];
    logic        layer_vis;
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_req;
    int          hold_left;
    int          idle_run;

    paint_layer_pixel_blend dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .dst_color       (dst_color),
        .dst_surface     (dst_surface),
        .dst_thickness   (dst_thickness),
        .layer_color     (layer_color),
        .layer_surface   (layer_surface),
        .layer_thickness (layer_thickness),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_color       (out_color),
        .out_surface     (out_surface),
        .out_thickness   (out_thickness),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    // clock, period 8
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // blended composite pixel for one layer pixel
    function automatic blend_px_t blend_over(input logic vis,
                                             input logic [31:0] dc, ds, dt, lc, ls,
                                             input logic [16:0] lt);
        blend_px_t       r;
        int unsigned     a;
        int unsigned     fac;
        int unsigned     d;
        int unsigned     l;
        int unsigned     v;
        longint unsigned th;
        if (!vis)
        begin
            r.color     = dc;
            r.surface   = ds;
            r.thickness = dt;
            return r;
        end
        a   = lc[31:24];
        fac = a * int'(ls[23:16]);
        // colour channels weighted by alpha times surface channel 2
        for (int k = 0; k < 3; k++)
        begin
            d = dc[8*k +: 8];
            l = lc[8*k +: 8];
            v = (d * (FAC_FULL - fac) + l * fac) / FAC_FULL;
            r.color[8*k +: 8] = v[7:0];
        end
        // coverage: 1 - (1 - da)(1 - a)
        d = dc[31:24];
        v = (FAC_FULL - (CH_FULL - d) * (CH_FULL - a)) / CH_FULL;
        r.color[31:24] = v[7:0];
        // surface channels weighted by alpha alone
        for (int k = 0; k < 4; k++)
        begin
            d = ds[8*k +: 8];
            l = ls[8*k +: 8];
            v = (d * (CH_FULL - a) + l * a) / CH_FULL;
            r.surface[8*k +: 8] = v[7:0];
        end
        // thickness accumulates, saturating
        th = 64'(dt) + (64'(lt) * 64'(a)) / 64'(CH_FULL);
        if (th > 64'(THICK_TOP))
            th = 64'(THICK_TOP);
        r.thickness = th[31:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        blend_px_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (blend_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no item waiting: %h %h %h",
                             out_color, out_surface, out_thickness);
            end
            else
            begin
                want = blend_q.pop_front();
                check_field("out_color", want.color, out_color);
                check_field("out_surface", want.surface, out_surface);
                check_field("out_thickness", want.thickness, out_thickness);
            end
        end
    end

    // receiver: random stall, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles with no item moving on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // offer one item, hold it until taken, then queue its prediction
    task automatic send_pixel(input logic [31:0] dc, ds, dt, lc, ls,
                              input logic [16:0] lt);
        blend_px_t expect_px;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        dst_color       <= dc;
        dst_surface     <= ds;
        dst_thickness   <= dt;
        layer_color     <= lc;
        layer_surface   <= ls;
        layer_thickness <= lt;
        in_valid        <= 1'b1;
        do @(posedge clk); while (in_stall);
        expect_px = blend_over(layer_vis, dc, ds, dt, lc, ls, lt);
        blend_q   = {blend_q, expect_px};
    endtask

    // random pixel, biased towards the alpha and factor extremes
    task automatic send_random_pixel();
        logic [31:0] dc, ds, dt, lc, ls;
        logic [16:0] lt;
        dc = $urandom;
        ds = $urandom;
        dt = $urandom;
        lc = $urandom;
        ls = $urandom;
        case ($urandom_range(3))
            0: lc[31:24] = 8'h00;
            1: lc[31:24] = 8'hFF;
            default: ;
        endcase
        case ($urandom_range(3))
            0: ls[23:16] = 8'h00;
            1: ls[23:16] = 8'hFF;
            default: ;
        endcase
        case ($urandom_range(3))
            0: dc[31:24] = 8'h00;
            1: dc[31:24] = 8'hFF;
            default: ;
        endcase
        case ($urandom_range(3))
            0: lt = 17'($urandom_range(65536));
            1: lt = 17'd65536;
            default: lt = 17'($urandom);
        endcase
        // near the top so the sum saturates now and then
        if ($urandom_range(7) == 0)
            dt = THICK_TOP - 32'($urandom_range(131071));
        send_pixel(dc, ds, dt, lc, ls, lt);
    endtask

    // stop offering, wait for every outstanding result, then let the pipe settle
    task automatic drain_all();
        in_valid <= 1'b0;
        while (blend_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // write the visibility register while the block is idle
    task automatic write_visible(input logic v);
        drain_all();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        layer_vis = v;
    endtask

    task automatic test_directed_extremes();
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        write_visible(1'b1);
        send_pixel(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'h0);
        send_pixel('1, '1, '1, '1, '1, 17'h1FFFF);
        // transparent layer
        send_pixel(32'h8040_C020, 32'h1234_5678, 32'h0001_0000,
                   32'h00FF_FFFF, 32'hFFFF_FFFF, 17'd65536);
        // opaque layer, full colour factor
        send_pixel(32'h1020_3040, 32'hA5A5_A5A5, 32'h0,
                   32'hFF80_90A0, 32'h00FF_0000, 17'd65536);
        // opaque layer, colour factor zero
        send_pixel(32'h1020_3040, 32'h5A5A_5A5A, 32'h0,
                   32'hFFC0_B0A0, 32'hFF00_FFFF, 17'd32768);
        send_pixel(32'h00FF_00FF, 32'h0, 32'h0,
                   32'h8000_FF00, 32'h0080_0000, 17'd1);
        send_pixel(32'hFF00_00FF, 32'hFFFF_FFFF, 32'h0,
                   32'h80FF_00FF, 32'h7F7F_7F7F, 17'd255);
        // thickness just saturates, and lands exactly on the top
        send_pixel(32'h0, 32'h0, 32'hFFFF_0000, 32'hFF00_0000, 32'h0, 17'd65536);
        send_pixel(32'h0, 32'h0, 32'hFFFE_FFFF, 32'hFF00_0000, 32'h0, 17'd65536);
        send_pixel(32'h0, 32'h0, 32'h0, 32'h0100_0000, 32'h0, 17'd65536);
        // layer thickness above one
        send_pixel(32'h0, 32'h0, 32'h8000_0000, 32'hFF00_0000, 32'h0, 17'h1FFFF);
        send_pixel(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'h5555_5555, 32'hAAAA_AAAA, 17'h15555);
        send_pixel(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'hAAAA_AAAA, 32'h5555_5555, 17'h0AAAA);
    endtask

    // invisible layer passes the composite through
    task automatic test_invisible_layer();
        write_visible(1'b0);
        send_pixel('1, '1, '1, '1, '1, 17'h1FFFF);
        send_pixel(32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_0000,
                   32'hFF80_90A0, 32'h00FF_0000, 17'd65536);
        send_pixel(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd65536);
        write_visible(1'b1);
    endtask

    task automatic test_random_stream(input logic vis, input int count,
                                      input int sp, input int rp);
        write_visible(vis);
        send_idle_pct  = sp;
        recv_stall_pct = rp;
        repeat (count) send_random_pixel();
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_output_hold();
        write_visible(1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = HOLD_LEN;
        repeat (24) send_random_pixel();
    endtask

    // sender pauses until every result has come back
    task automatic test_sender_pause();
        send_idle_pct  = 22;
        recv_stall_pct = 64;
        repeat (8) send_random_pixel();
        drain_all();
        repeat (8) send_random_pixel();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        dst_color       = '0;
        dst_surface     = '0;
        dst_thickness   = '0;
        layer_color     = '0;
        layer_surface   = '0;
        layer_thickness = '0;
        out_stall       = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = 1'b0;
        layer_vis       = 1'b1;
        mismatches      = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_req        = 0;
        hold_left       = 0;
        idle_run        = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_invisible_layer();
        test_output_hold();
        test_sender_pause();
        test_random_stream(1'b1, 120, 22, 64);
        test_random_stream(1'b0, 30, 22, 64);
        test_random_stream(1'b1, 120, 64, 22);
        test_random_stream(1'b0, 30, 64, 22);
        test_random_stream(1'b1, 100, 0, 0);

        drain_all();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && blend_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
